/* rtl/core/dtfp_pkg.sv */
// Package for the display touch frame parser: frame constants, register
// indexes, parser phase codes and the structs passed between modules.
// Depends on nothing.
package dtfp_pkg;

    localparam logic [7:0] HEAD_FIRST     = 8'h5a;
    localparam logic [7:0] HEAD_SECOND    = 8'ha5;
    localparam logic [7:0] CMD_READ_REPLY = 8'h83;

    localparam logic [7:0] MIN_FRAME_LENGTH = 8'd3;
    localparam logic [7:0] MIN_KEY_LENGTH   = 8'd6;
    localparam logic [7:0] POS_COMMAND      = 8'd1;
    localparam logic [7:0] POS_ADDR_HIGH    = 8'd2;
    localparam logic [7:0] POS_KEY_HIGH     = 8'd5;
    localparam logic [7:0] POS_KEY_LOW      = 8'd6;
    localparam logic [7:0] POS_TEXT_FIRST   = 8'd5;

    localparam logic [7:0]  RESET_TEXT_LENGTH  = 8'd16;
    localparam logic [15:0] RESET_KEY_ADDRESS  = 16'h0800;
    localparam logic [15:0] RESET_TEXT_ADDRESS = 16'h0790;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEXT_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KEY_ADDRESS  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEXT_ADDRESS = 2'd2;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    typedef enum logic [5:0] {
        PH_HUNT1  = 6'b000001,
        PH_HUNT2  = 6'b000010,
        PH_LENGTH = 6'b000100,
        PH_HEADER = 6'b001000,
        PH_KEY    = 6'b010000,
        PH_TEXT   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]  text_length;
        logic [15:0] key_address;
        logic [15:0] text_address;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] key_value;
        logic        has_byte;
        logic [7:0]  text_byte;
        logic        last;
    } result_t;

endpackage

/* rtl/core/display_touch_frame_parser_core.sv */
// Top level of the display touch frame parser: input byte register, result
// register and the stream and configuration ports.
// Depends on dtfp_pkg, dtfp_cfg_regs and dtfp_parser.
//
// The block takes one received byte per clock cycle on the slave stream while
// the master side is not stalled, and gives at most one result word per byte on
// the master stream. Each byte passes through the input register, the frame
// state machine and then the result register. A byte can be taken in every
// cycle while results are taken as fast; when the master side stalls, the input
// register still takes a byte only while it is empty, and s_tready falls once it
// holds one. Configuration writes are accepted in any cycle and should be made
// while no frame is in progress.
module display_touch_frame_parser_core
    import dtfp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // [7:0] rx_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,    // [15:0] key_value, [16] has_byte,
                                                   // [24:17] text_byte, [31:25] zero
    output logic                       m_tuser,    // [0] kind
    output logic                       m_tlast,    // last
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic [7:0] in_byte_reg;
    logic    advance;
    logic    step;
    logic    step_res_valid;
    result_t step_res;
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;

    assign cfg_ready = 1'b1;

    dtfp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = !res_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    dtfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = step && step_res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (step && step_res_valid)
            res_reg <= step_res;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_reg.text_byte, res_reg.has_byte, res_reg.key_value};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    // A key result always closes its frame and never carries a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_KEY) |-> (m_tlast && !m_tdata[16]))
        else $error("key result without last or with a character");

    // A result without a character carries a zero byte and is the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[24:17] == 8'h00 && m_tlast))
        else $error("empty result with a byte or without last");

    // The input side only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && in_valid_reg))
        else $error("input stalled without a held result");

    // A result that is waiting stays unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_reg)))
        else $error("held result changed");

endmodule

/* rtl/core/dtfp_cfg_regs.sv */
// Configuration register file of the display touch frame parser.
// Depends on dtfp_pkg for register indexes, reset values and cfg_t.
module dtfp_cfg_regs
    import dtfp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_TEXT_LENGTH:  cfg_next.text_length  = wr_data[7:0];
                CFG_KEY_ADDRESS:  cfg_next.key_address  = wr_data;
                CFG_TEXT_ADDRESS: cfg_next.text_address = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_length  <= RESET_TEXT_LENGTH;
            cfg_reg.key_address  <= RESET_KEY_ADDRESS;
            cfg_reg.text_address <= RESET_TEXT_ADDRESS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/dtfp_parser.sv */
// Frame parser state machine: holds the frame state and works out, for one
// byte, the next state and the result that the byte causes.
// Depends on dtfp_pkg for phase codes, frame constants and structs.
module dtfp_parser
    import dtfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  byte_position_reg, byte_position_next;
    logic [15:0] frame_address_reg, frame_address_next;
    logic [15:0] held_value_reg, held_value_next;
    logic [7:0]  text_count_reg, text_count_next;

    logic [7:0]  pos_inc;
    logic [15:0] addr_full;
    logic [7:0]  count_inc;
    logic        at_end;

    assign pos_inc   = byte_position_reg + 8'd1;
    assign addr_full = frame_address_reg | {8'h00, rx_byte};
    assign count_inc = text_count_reg + 8'd1;
    assign at_end    = (pos_inc == frame_length_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        byte_position_next = byte_position_reg;
        frame_address_next = frame_address_reg;
        held_value_next    = held_value_reg;
        text_count_next    = text_count_reg;
        res_valid          = 1'b0;
        res.kind           = KIND_TEXT;
        res.key_value      = frame_address_reg;
        res.has_byte       = 1'b0;
        res.text_byte      = 8'h00;
        res.last           = 1'b1;
        case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == HEAD_FIRST)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (rx_byte == HEAD_SECOND)
                    phase_next = PH_LENGTH;
                else if (rx_byte != HEAD_FIRST)
                    phase_next = PH_HUNT1;
            end
            PH_LENGTH:
            begin
                frame_length_next  = rx_byte;
                byte_position_next = 8'd0;
                phase_next = (rx_byte < MIN_FRAME_LENGTH) ? PH_HUNT1 : PH_HEADER;
            end
            PH_HEADER:
            begin
                byte_position_next = pos_inc;
                if (pos_inc == POS_COMMAND)
                begin
                    if (rx_byte != CMD_READ_REPLY)
                        phase_next = PH_HUNT1;
                end
                else if (pos_inc == POS_ADDR_HIGH)
                begin
                    frame_address_next = {rx_byte, 8'h00};
                end
                else
                begin
                    frame_address_next = addr_full;
                    if (addr_full == cfg.key_address)
                    begin
                        phase_next = (frame_length_reg < MIN_KEY_LENGTH) ? PH_HUNT1 : PH_KEY;
                    end
                    else if (addr_full == cfg.text_address)
                    begin
                        text_count_next = 8'd0;
                        if (at_end)
                        begin
                            phase_next    = PH_HUNT1;
                            res_valid     = 1'b1;
                            res.key_value = addr_full;
                        end
                        else
                        begin
                            phase_next = PH_TEXT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
            end
            PH_KEY:
            begin
                byte_position_next = pos_inc;
                if (pos_inc == POS_KEY_HIGH)
                    held_value_next = {rx_byte, held_value_reg[7:0]};
                else if (pos_inc == POS_KEY_LOW)
                    held_value_next = {held_value_reg[15:8], rx_byte};
                if (at_end)
                begin
                    phase_next    = PH_HUNT1;
                    res_valid     = 1'b1;
                    res.kind      = KIND_KEY;
                    res.key_value = held_value_next;
                end
            end
            PH_TEXT:
            begin
                byte_position_next = pos_inc;
                if (at_end)
                    phase_next = PH_HUNT1;
                if (pos_inc >= POS_TEXT_FIRST && text_count_reg < cfg.text_length)
                begin
                    text_count_next = count_inc;
                    res_valid       = 1'b1;
                    res.has_byte    = 1'b1;
                    res.text_byte   = rx_byte;
                    res.last        = at_end || (count_inc == cfg.text_length);
                end
                else if (at_end && text_count_reg == 8'd0)
                begin
                    res_valid = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            frame_length_reg  <= 8'd0;
            byte_position_reg <= 8'd0;
            frame_address_reg <= 16'd0;
            held_value_reg    <= 16'd0;
            text_count_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            byte_position_reg <= byte_position_next;
            frame_address_reg <= frame_address_next;
            held_value_reg    <= held_value_next;
            text_count_reg    <= text_count_next;
        end
    end

endmodule
